FILE: sv/kcs_pkg.sv
// Shared types and constants for the keyframe curve sampler.
// No dependencies; every other file of the block but kcs_ram uses this package.
`default_nettype none

package kcs_pkg;

  // Fixed-point format and table sizes
  localparam int FRAC_BITS    = 16;
  localparam int SEARCH_STEPS = 20;
  localparam int MAX_KEYS     = 64;
  localparam int MAX_PARAMS   = 4;

  localparam int KEY_W    = $clog2(MAX_KEYS);
  localparam int PAR_W    = $clog2(MAX_PARAMS);
  localparam int DADDR_W  = KEY_W + PAR_W;
  localparam int STEP_W   = $clog2(SEARCH_STEPS);
  localparam int DCNT_W   = $clog2(FRAC_BITS);
  localparam int NKEYS_W  = 7;
  localparam int NPAR_W   = 3;
  localparam int CFG_DW   = 7;

  // Bezier search: unit interval and convergence window
  localparam int FX_W = FRAC_BITS + 1;
  localparam logic [FX_W-1:0] ONE_FX = FX_W'(1) << FRAC_BITS;
  localparam int EPS_INT = ((1 << FRAC_BITS) + 500) / 1000;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_KEYS   = 1'b0,
    CFG_PARAMS = 1'b1
  } cfg_index_t;

  typedef enum logic [0:0] {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_t;

  typedef enum logic [0:0] {
    MODE_LINEAR = 1'b0,
    MODE_BEZIER = 1'b1
  } interp_mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_SEG  = 2'd1,
    ST_NO_CONV = 2'd2,
    ST_WRITE   = 2'd3
  } status_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic              is_sample;
    logic [KEY_W-1:0]  key_index;
    logic [PAR_W-1:0]  param_index;
    logic [31:0]       item_time;
    logic [31:0]       key_value;
    logic [31:0]       in_x;
    logic [31:0]       in_y;
    logic [31:0]       out_x;
    logic [31:0]       out_y;
    logic              mode;
  } cmd_t;

  // One parameter's entry in the data memory
  typedef struct packed {
    logic [31:0] key_value;
    logic [31:0] in_x;
    logic [31:0] in_y;
    logic [31:0] out_x;
    logic [31:0] out_y;
  } entry_t;

  // One result item
  typedef struct packed {
    logic [PAR_W-1:0] out_param;
    logic [31:0]      out_value;
    status_t          status;
    logic             last;
  } res_t;

  // Queue status seen by the back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

endpackage

`default_nettype wire

FILE: sv/kcs_if.sv
// Handshake channels of the keyframe curve sampler: item in, result out.
// Depends on kcs_pkg for field widths.
`default_nettype none

interface kcs_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [kcs_pkg::KEY_W-1:0]   key_index;
  logic [kcs_pkg::PAR_W-1:0]   param_index;
  logic signed [31:0]          key_time;
  logic signed [31:0]          key_value;
  logic signed [31:0]          in_tangent_x;
  logic signed [31:0]          in_tangent_y;
  logic signed [31:0]          out_tangent_x;
  logic signed [31:0]          out_tangent_y;
  logic                        interp_mode;
  logic signed [31:0]          sample_time;

  modport source (
    output valid, opcode, key_index, param_index, key_time, key_value,
           in_tangent_x, in_tangent_y, out_tangent_x, out_tangent_y,
           interp_mode, sample_time,
    input  ready
  );
  modport sink (
    input  valid, opcode, key_index, param_index, key_time, key_value,
           in_tangent_x, in_tangent_y, out_tangent_x, out_tangent_y,
           interp_mode, sample_time,
    output ready
  );
endinterface

interface kcs_out_if;
  logic                        valid;
  logic                        ready;
  logic [kcs_pkg::PAR_W-1:0]   out_param;
  logic signed [31:0]          out_value;
  logic [1:0]                  status;
  logic                        last;

  modport source (output valid, out_param, out_value, status, last, input ready);
  modport sink   (input valid, out_param, out_value, status, last, output ready);
endinterface

`default_nettype wire

FILE: sv/kcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module kcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/kcs_front.sv
// Front of the sampler: accepts items, classifies them and queues them.
// Depends on kcs_pkg and kcs_if.
`default_nettype none

module kcs_front (
  input  wire logic           clk,
  input  wire logic           rst,
  kcs_in_if.sink              in_ch,
  input  wire logic           pop,
  output kcs_pkg::head_t      head
);

  kcs_pkg::cmd_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;
  kcs_pkg::cmd_t cmd_in;

  assign in_ch.ready = (count != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;

  // Classify: a sample carries its sample time in the time slot
  always_comb begin
    cmd_in.is_sample   = (in_ch.opcode == kcs_pkg::OP_SAMPLE);
    cmd_in.key_index   = in_ch.key_index;
    cmd_in.param_index = in_ch.param_index;
    cmd_in.item_time   = cmd_in.is_sample ? in_ch.sample_time : in_ch.key_time;
    cmd_in.key_value   = in_ch.key_value;
    cmd_in.in_x        = in_ch.in_tangent_x;
    cmd_in.in_y        = in_ch.in_tangent_y;
    cmd_in.out_x       = in_ch.out_tangent_x;
    cmd_in.out_y       = in_ch.out_tangent_y;
    cmd_in.mode        = in_ch.interp_mode;
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.cmd   = entries[rd_ptr];

endmodule

`default_nettype wire

FILE: sv/kcs_interp.sv
// Interpolation unit: linear ratio by restoring division, or bezier bisection.
// Depends on kcs_pkg.
`default_nettype none

module kcs_interp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               mode,
  input  wire logic signed [31:0] t,
  input  wire logic signed [31:0] t0,
  input  wire logic signed [31:0] t1,
  input  wire logic signed [31:0] v0,
  input  wire logic signed [31:0] v1,
  input  wire logic signed [31:0] c0x,
  input  wire logic signed [31:0] c0y,
  input  wire logic signed [31:0] c1x,
  input  wire logic signed [31:0] c1y,
  output logic                    done,
  output logic [31:0]             value,
  output kcs_pkg::status_t        status
);

  localparam int FB  = kcs_pkg::FRAC_BITS;
  localparam int FXW = kcs_pkg::FX_W;
  localparam int WW  = FXW + 2;          // weight width after times three
  localparam int PW  = 32 + WW + 1;      // coord times weight
  localparam int SW  = PW + 2;           // sum of four terms
  localparam int XW  = SW - FB;          // curve point
  localparam logic signed [XW:0] EPS = (XW+1)'(kcs_pkg::EPS_INT);

  typedef enum logic [8:0] {
    I_IDLE = 9'b000000001,
    I_DIV  = 9'b000000010,
    I_LMUL = 9'b000000100,
    I_LADD = 9'b000001000,
    I_W1   = 9'b000010000,
    I_W2   = 9'b000100000,
    I_MUL  = 9'b001000000,
    I_SUM  = 9'b010000000,
    I_CHK  = 9'b100000000
  } istate_t;

  istate_t state;

  // Operands
  logic signed [31:0] t_r, v0_r;
  logic signed [31:0] cx [4];
  logic signed [31:0] cy [4];
  logic signed [32:0] dv;

  // Divider
  logic [33:0]            rem;
  logic [32:0]            dvsr;
  logic [FB-1:0]          quot;
  logic [kcs_pkg::DCNT_W-1:0] dcnt;
  logic [33:0]            rem_sh;
  logic signed [FB+33:0]  lprod;
  logic signed [34:0]     lsum;

  // Bisection
  logic [FXW-1:0]     lo, hi, s_r, u_r, u2, s2;
  logic [FXW:0]       mid_sum;
  logic [FXW-1:0]     s_c, u_c;
  logic [2*FXW-1:0]   uu, ss, wm0, wm1, wm2, wm3;
  logic [WW-1:0]      w [4];
  logic signed [PW-1:0] px [4];
  logic signed [PW-1:0] py [4];
  logic signed [SW-1:0] sumx, sumy;
  logic signed [XW-1:0] xr, yr;
  logic signed [XW:0]   diff;
  logic                 conv;
  logic [kcs_pkg::STEP_W-1:0] step;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign s_c     = mid_sum[FXW:1];
  assign u_c     = kcs_pkg::ONE_FX - s_c;
  assign uu      = u_c * u_c;
  assign ss      = s_c * s_c;
  assign wm0     = u2 * u_r;
  assign wm1     = s_r * u2;
  assign wm2     = s2 * u_r;
  assign wm3     = s2 * s_r;
  assign rem_sh  = {rem[32:0], 1'b0};
  assign lsum    = 35'(v0_r) + 35'(lprod >>> FB);
  assign diff    = (XW+1)'(xr) - (XW+1)'(t_r);
  assign conv    = (diff < EPS) && (diff > -EPS);

  // Sum the weighted control points
  always_comb begin
    sumx = '0;
    sumy = '0;
    for (int k = 0; k < 4; k++) begin
      sumx = sumx + SW'(px[k]);
      sumy = sumy + SW'(py[k]);
    end
  end

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= I_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        I_IDLE: begin
          if (start) begin
            t_r   <= t;
            v0_r  <= v0;
            dv    <= 33'(v1) - 33'(v0);
            cx[0] <= t0;  cx[1] <= c0x; cx[2] <= c1x; cx[3] <= t1;
            cy[0] <= v0;  cy[1] <= c0y; cy[2] <= c1y; cy[3] <= v1;
            rem   <= 34'(33'(t) - 33'(t0));
            dvsr  <= 33'(t1) - 33'(t0);
            quot  <= '0;
            dcnt  <= '0;
            lo    <= '0;
            hi    <= kcs_pkg::ONE_FX;
            step  <= '0;
            state <= (mode == kcs_pkg::MODE_BEZIER) ? I_W1 : I_DIV;
          end
        end
        // One quotient bit per cycle
        I_DIV: begin
          if (rem_sh >= {1'b0, dvsr}) begin
            rem  <= rem_sh - {1'b0, dvsr};
            quot <= {quot[FB-2:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            quot <= {quot[FB-2:0], 1'b0};
          end
          dcnt <= dcnt + 1'b1;
          if (dcnt == kcs_pkg::DCNT_W'(FB - 1)) state <= I_LMUL;
        end
        I_LMUL: begin
          lprod <= $signed({1'b0, quot}) * dv;
          state <= I_LADD;
        end
        I_LADD: begin
          if (lsum > 35'sh07FFFFFFF)       value <= 32'h7FFF_FFFF;
          else if (lsum < -35'sh080000000) value <= 32'h8000_0000;
          else                              value <= lsum[31:0];
          status <= kcs_pkg::ST_OK;
          done   <= 1'b1;
          state  <= I_IDLE;
        end
        // Midpoint and squares
        I_W1: begin
          s_r   <= s_c;
          u_r   <= u_c;
          u2    <= uu[FB+FXW-1:FB];
          s2    <= ss[FB+FXW-1:FB];
          state <= I_W2;
        end
        // Bernstein weights
        I_W2: begin
          w[0]  <= WW'(wm0[FB+FXW-1:FB]);
          w[1]  <= WW'(wm1[FB+FXW-1:FB]) + {WW'(wm1[FB+FXW-1:FB]) << 1};
          w[2]  <= WW'(wm2[FB+FXW-1:FB]) + {WW'(wm2[FB+FXW-1:FB]) << 1};
          w[3]  <= WW'(wm3[FB+FXW-1:FB]);
          state <= I_MUL;
        end
        I_MUL: begin
          for (int k = 0; k < 4; k++) begin
            px[k] <= cx[k] * $signed({1'b0, w[k]});
            py[k] <= cy[k] * $signed({1'b0, w[k]});
          end
          state <= I_SUM;
        end
        I_SUM: begin
          xr    <= XW'(sumx >>> FB);
          yr    <= XW'(sumy >>> FB);
          state <= I_CHK;
        end
        // Test convergence and the step limit: finish with the result, or narrow the interval
        I_CHK: begin
          if (conv || step == kcs_pkg::STEP_W'(kcs_pkg::SEARCH_STEPS - 1)) begin
            if (yr > XW'(32'sh7FFFFFFF))       value <= 32'h7FFF_FFFF;
            else if (yr < -XW'(33'sh80000000)) value <= 32'h8000_0000;
            else                                value <= yr[31:0];
            status <= conv ? kcs_pkg::ST_OK : kcs_pkg::ST_NO_CONV;
            done   <= 1'b1;
            state  <= I_IDLE;
          end else begin
            if (xr > XW'(t_r)) hi <= s_r;
            else               lo <= s_r;
            step  <= step + 1'b1;
            state <= I_W1;
          end
        end
        default: state <= I_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/kcs_back.sv
// Back of the sampler: key and data memories, segment scan, per-parameter
// evaluation and the result register. Depends on kcs_pkg, kcs_ram, kcs_interp.
`default_nettype none

module kcs_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire kcs_pkg::head_t                 head,
  output logic                                pop,
  input  wire logic [kcs_pkg::NKEYS_W-1:0]    nkeys,
  input  wire logic [kcs_pkg::NPAR_W-1:0]     npar,
  output logic                                res_valid,
  input  wire logic                           res_ready,
  output kcs_pkg::res_t                       res
);

  localparam int KW = kcs_pkg::KEY_W;
  localparam int PWD = kcs_pkg::PAR_W;

  typedef enum logic [8:0] {
    B_IDLE    = 9'b000000001,
    B_SCAN_RD = 9'b000000010,
    B_SCAN_CM = 9'b000000100,
    B_PARAM   = 9'b000001000,
    B_PRD0    = 9'b000010000,
    B_PRD1    = 9'b000100000,
    B_START   = 9'b001000000,
    B_CALC    = 9'b010000000,
    B_EMIT    = 9'b100000000
  } bstate_t;

  bstate_t state;

  logic signed [31:0] t_r, prev_time, t0, t1, v0, v1, c0x, c0y, c1x, c1y;
  logic               prev_mode, seg_mode, found;
  logic [KW-1:0]      scan_idx, seg;
  logic [PWD-1:0]     par;
  kcs_pkg::res_t      pend;
  logic               slot_free;

  // Memories
  logic               t_we, d_we;
  logic [KW-1:0]      t_raddr;
  logic [32:0]        t_rdata;
  logic [kcs_pkg::DADDR_W-1:0] d_waddr, d_raddr;
  kcs_pkg::entry_t    d_wdata, d_rdata;
  logic signed [31:0] cur_time;
  logic               cur_mode;
  logic               last_par;

  // Interpolation unit
  logic               i_start, i_done;
  logic [31:0]        i_value;
  kcs_pkg::status_t   i_status;

  assign pop       = (state == B_IDLE) && head.valid;
  assign t_we      = pop && !head.cmd.is_sample;
  assign d_we      = t_we;
  assign d_waddr   = {head.cmd.key_index, head.cmd.param_index};
  assign d_wdata   = '{key_value: head.cmd.key_value, in_x: head.cmd.in_x,
                       in_y: head.cmd.in_y, out_x: head.cmd.out_x,
                       out_y: head.cmd.out_y};
  assign t_raddr   = scan_idx;
  assign d_raddr   = (state == B_PRD0) ? {seg + 1'b1, par} : {seg, par};
  assign cur_time  = t_rdata[31:0];
  assign cur_mode  = t_rdata[32];
  assign last_par  = ({1'b0, par} == kcs_pkg::NPAR_W'(npar - 1'b1));
  assign slot_free = !res_valid || res_ready;
  assign i_start   = (state == B_START);

  kcs_ram #(.WIDTH(33), .DEPTH(kcs_pkg::MAX_KEYS)) u_time_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (head.cmd.key_index),
    .wdata ({head.cmd.mode, head.cmd.item_time}),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  kcs_ram #(.WIDTH($bits(kcs_pkg::entry_t)),
            .DEPTH(kcs_pkg::MAX_KEYS * kcs_pkg::MAX_PARAMS)) u_data_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  kcs_interp u_interp (
    .clk    (clk),
    .rst    (rst),
    .start  (i_start),
    .mode   (seg_mode),
    .t      (t_r),
    .t0     (t0),
    .t1     (t1),
    .v0     (v0),
    .v1     (v1),
    .c0x    (c0x),
    .c0y    (c0y),
    .c1x    (c1x),
    .c1y    (c1y),
    .done   (i_done),
    .value  (i_value),
    .status (i_status)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == B_EMIT && slot_free) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_EMIT && slot_free) begin
      res <= pend;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (head.valid) begin
            t_r      <= head.cmd.item_time;
            par      <= '0;
            scan_idx <= '0;
            found    <= 1'b0;
            if (!head.cmd.is_sample) begin
              pend  <= '{out_param: head.cmd.param_index, out_value: 32'd0,
                         status: kcs_pkg::ST_WRITE, last: 1'b1};
              state <= B_EMIT;
            end else if (nkeys < kcs_pkg::NKEYS_W'(2)) begin
              state <= B_PARAM;
            end else begin
              state <= B_SCAN_RD;
            end
          end
        end
        B_SCAN_RD: state <= B_SCAN_CM;
        // Compare this key with the one before it
        B_SCAN_CM: begin
          if (scan_idx != '0 && prev_time <= t_r && cur_time > t_r) begin
            found    <= 1'b1;
            seg      <= scan_idx - 1'b1;
            seg_mode <= prev_mode;
            t0       <= prev_time;
            t1       <= cur_time;
            state    <= B_PARAM;
          end else begin
            prev_time <= cur_time;
            prev_mode <= cur_mode;
            if ({1'b0, scan_idx} == nkeys - 1'b1) begin
              state <= B_PARAM;
            end else begin
              scan_idx <= scan_idx + 1'b1;
              state    <= B_SCAN_RD;
            end
          end
        end
        B_PARAM: begin
          if (!found) begin
            pend  <= '{out_param: par, out_value: 32'd0,
                       status: kcs_pkg::ST_NO_SEG, last: last_par};
            state <= B_EMIT;
          end else begin
            state <= B_PRD0;
          end
        end
        // Entry of the first key arrives
        B_PRD0: begin
          v0    <= d_rdata.key_value;
          c0x   <= d_rdata.out_x;
          c0y   <= d_rdata.out_y;
          state <= B_PRD1;
        end
        // Entry of the second key arrives
        B_PRD1: begin
          v1    <= d_rdata.key_value;
          c1x   <= d_rdata.in_x;
          c1y   <= d_rdata.in_y;
          state <= B_START;
        end
        B_START: state <= B_CALC;
        B_CALC: begin
          if (i_done) begin
            pend  <= '{out_param: par, out_value: i_value,
                       status: i_status, last: last_par};
            state <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (slot_free) begin
            if (pend.last) begin
              state <= B_IDLE;
            end else begin
              par   <= par + 1'b1;
              state <= B_PARAM;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/keyframe_curve_sampler_core.sv
// Keyframe curve sampler: a write item stores one key's time, mode, value and
// tangents for one parameter and returns one write-done result; a sample item
// finds the first segment holding its time and returns one Q16.16 value per
// parameter in use. Items are queued and run one at a time. A sample scans the
// key memory key by key through its single read port, then per parameter reads
// the two entries, starts the interpolation and emits, with a linear segment
// done by division (one quotient bit per cycle) or a bezier segment by
// bisection. Configuration: cfg_we, cfg_index (0 keys_in_use, 1 params_in_use),
// cfg_data. Memories start undefined; sample only written keys.
`default_nettype none

module keyframe_curve_sampler_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  kcs_in_if.sink                          in_ch,
  kcs_out_if.source                       out_ch,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [kcs_pkg::CFG_DW-1:0] cfg_data
);

  logic [kcs_pkg::NKEYS_W-1:0] keys_in_use, nkeys;
  logic [kcs_pkg::NPAR_W-1:0]  params_in_use, npar;
  kcs_pkg::head_t              head;
  logic                        pop;
  kcs_pkg::res_t               res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      keys_in_use   <= '0;
      params_in_use <= kcs_pkg::NPAR_W'(1);
    end else if (cfg_we) begin
      unique case (kcs_pkg::cfg_index_t'(cfg_index))
        kcs_pkg::CFG_KEYS:   keys_in_use   <= cfg_data[kcs_pkg::NKEYS_W-1:0];
        kcs_pkg::CFG_PARAMS: params_in_use <= cfg_data[kcs_pkg::NPAR_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp counts to the table size; zero parameters count as one
  assign nkeys = (keys_in_use > kcs_pkg::NKEYS_W'(kcs_pkg::MAX_KEYS))
               ? kcs_pkg::NKEYS_W'(kcs_pkg::MAX_KEYS) : keys_in_use;
  assign npar  = (params_in_use == '0) ? kcs_pkg::NPAR_W'(1)
               : (params_in_use > kcs_pkg::NPAR_W'(kcs_pkg::MAX_PARAMS))
               ? kcs_pkg::NPAR_W'(kcs_pkg::MAX_PARAMS) : params_in_use;

  kcs_front u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .pop   (pop),
    .head  (head)
  );

  kcs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .nkeys     (nkeys),
    .npar      (npar),
    .res_valid (out_ch.valid),
    .res_ready (out_ch.ready),
    .res       (res)
  );

  assign out_ch.out_param = res.out_param;
  assign out_ch.out_value = res.out_value;
  assign out_ch.status    = res.status;
  assign out_ch.last      = res.last;

endmodule

`default_nettype wire
